@@ hw/rtl/taf_pkg.sv @@
// package for the translational admittance filter: widths, control word type
// and the microprogram rom; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package taf_pkg;

   localparam int AXES      = 3;
   localparam int AX_W      = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int ACC_W     = 48;
   localparam int MA_W      = 33;
   localparam int PROD_W    = 58;
   localparam int PC_W      = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 31;

   // register index map
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_LIMIT = 3'd4;

   localparam logic [23:0] RST_INV_MASS    = 24'd559241;
   localparam logic [23:0] RST_STIFFNESS   = 24'd38400;
   localparam logic [23:0] RST_DAMPING     = 24'd6869;
   localparam logic [23:0] RST_TIME_STEP   = 24'd33554;
   localparam logic [30:0] RST_FORCE_LIMIT = 31'd4587520;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } taf_state_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_JMP_TRIP, SEQ_LOOP, SEQ_DONE
   } taf_seq_type;

   typedef enum logic [1:0] {
      MA_VEL, MA_POS, MA_ACC
   } taf_mul_a_type;

   typedef enum logic [1:0] {
      MB_DAMP, MB_STIFF, MB_IMASS, MB_TSTEP
   } taf_mul_b_type;

   typedef enum logic [1:0] {
      RS_16, RS_17, RS_24, RS_25
   } taf_rnd_type;

   typedef enum logic [2:0] {
      L_ACC, L_FORCE, L_VEL, L_POS, L_ZERO
   } taf_left_type;

   typedef enum logic [1:0] {
      R_ZERO, R_RND, R_PACC, R_PVEL
   } taf_right_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_PACC, WR_VEL, WR_POS
   } taf_wr_type;

   typedef struct packed {
      taf_seq_type   seq;
      logic [PC_W-1:0] target;
      logic          mul_en;
      taf_mul_a_type a_sel;
      taf_mul_b_type b_sel;
      taf_rnd_type   shift;
      logic          acc_en;
      taf_left_type  l_sel;
      taf_right_type r_sel;
      logic          r_neg;
      logic          sat;
      taf_wr_type    wr;
   } taf_uop_type;

   localparam logic [PC_W-1:0] PC_AXIS = 4'd1;
   localparam logic [PC_W-1:0] PC_DONE = 4'd13;

   localparam taf_uop_type UOP_NOP = '{
      seq: SEQ_NEXT, target: '0, mul_en: 1'b0, a_sel: MA_VEL, b_sel: MB_DAMP,
      shift: RS_16, acc_en: 1'b0, l_sel: L_ACC, r_sel: R_ZERO, r_neg: 1'b0,
      sat: 1'b0, wr: WR_NONE
   };

   // one control word per step; steps 1..12 run once per axis
   function automatic taf_uop_type taf_rom(input logic [PC_W-1:0] pc);
      taf_uop_type u;
      u = UOP_NOP;
      case (pc)
         4'd0: begin
            u.seq    = SEQ_JMP_TRIP;
            u.target = PC_DONE;
         end
         4'd1: begin
            u.mul_en = 1'b1; u.a_sel = MA_VEL; u.b_sel = MB_DAMP;
            u.acc_en = 1'b1; u.l_sel = L_FORCE; u.r_sel = R_ZERO;
         end
         4'd2: begin
            u.mul_en = 1'b1; u.a_sel = MA_POS; u.b_sel = MB_STIFF;
            u.acc_en = 1'b1; u.l_sel = L_ACC; u.r_sel = R_RND; u.r_neg = 1'b1;
            u.shift  = RS_16;
         end
         4'd3: begin
            u.acc_en = 1'b1; u.l_sel = L_ACC; u.r_sel = R_RND; u.r_neg = 1'b1;
            u.shift  = RS_16; u.sat = 1'b1;
         end
         4'd4: begin
            u.mul_en = 1'b1; u.a_sel = MA_ACC; u.b_sel = MB_IMASS;
         end
         4'd5: begin
            u.acc_en = 1'b1; u.l_sel = L_ZERO; u.r_sel = R_RND;
            u.shift  = RS_24; u.sat = 1'b1;
         end
         4'd6: begin
            u.acc_en = 1'b1; u.l_sel = L_ACC; u.r_sel = R_PACC;
            u.wr     = WR_PACC;
         end
         4'd7: begin
            u.mul_en = 1'b1; u.a_sel = MA_ACC; u.b_sel = MB_TSTEP;
         end
         4'd8: begin
            u.acc_en = 1'b1; u.l_sel = L_VEL; u.r_sel = R_RND;
            u.shift  = RS_17; u.sat = 1'b1;
         end
         4'd9: begin
            u.acc_en = 1'b1; u.l_sel = L_ACC; u.r_sel = R_PVEL;
            u.wr     = WR_VEL;
         end
         4'd10: begin
            u.mul_en = 1'b1; u.a_sel = MA_ACC; u.b_sel = MB_TSTEP;
         end
         4'd11: begin
            u.acc_en = 1'b1; u.l_sel = L_POS; u.r_sel = R_RND;
            u.shift  = RS_25; u.sat = 1'b1;
         end
         4'd12: begin
            u.wr     = WR_POS;
            u.seq    = SEQ_LOOP;
            u.target = PC_AXIS;
         end
         default: begin
            u.seq = SEQ_DONE;
         end
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/translational_admittance_filter_top.sv @@
// translational admittance filter top level: microcoded datapath, state,
// configuration registers and result register; depends on taf_pkg
`timescale 1ns / 1ps
`default_nettype none

// Mass-spring-damper admittance filter, three axes, trapezoidal integration.
// An item is taken when req_valid is high and req_stall low; req_stall is high
// while an item is being processed. Each item runs a 14-step microprogram over
// one shared 33x25 multiplier and one 48-bit accumulator: one trip check step,
// 12 steps per axis and one step that loads the result register, which waits
// while a previous result is held by rsp_stall. The next item is accepted only
// after the result register has been loaded. Once tripped an item goes straight
// from the trip check step to the result step. The result register lets a new
// item start while the previous result still waits behind rsp_stall.
// Configuration writes (csr_ready is always high) are meant for idle periods;
// indices beyond force_limit are ignored.
module translational_admittance_filter_top
   import taf_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [31:0]          req_force_x,
   input  wire logic signed [31:0]          req_force_y,
   input  wire logic signed [31:0]          req_force_z,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [31:0]               rsp_vel_x,
   output logic signed [31:0]               rsp_vel_y,
   output logic signed [31:0]               rsp_vel_z,
   output logic signed [31:0]               rsp_pos_x,
   output logic signed [31:0]               rsp_pos_y,
   output logic signed [31:0]               rsp_pos_z,
   output logic                             rsp_tripped,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DAT_W-1:0]        csr_wdata
);

   localparam logic signed [ACC_W-1:0] SAT_MAX = 48'sd2147483647;
   localparam logic signed [ACC_W-1:0] SAT_MIN = -48'sd2147483648;

   // configuration
   logic [23:0] inv_mass_ff, stiffness_ff, damping_ff, time_step_ff;
   logic [30:0] force_limit_ff;

   // control
   taf_state_type   state_ff;
   logic [PC_W-1:0] pc_ff;
   logic [AX_W-1:0] ax_ff;
   logic            trip_ff;
   logic            rsp_valid_ff;
   taf_uop_type     uop;

   // datapath and state
   logic signed [31:0]       force_ff [AXES];
   logic signed [31:0]       vel_ff   [AXES];
   logic signed [31:0]       pos_ff   [AXES];
   logic signed [31:0]       pacc_ff  [AXES];
   logic signed [31:0]       pvel_ff  [AXES];
   logic signed [PROD_W-1:0] p_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // result register
   logic signed [31:0] rsp_vel_ff [AXES];
   logic signed [31:0] rsp_pos_ff [AXES];
   logic               rsp_tripped_ff;

   logic signed [MA_W-1:0]   mul_a;
   logic [23:0]              mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rnd_sum, rnd_shifted;
   logic signed [ACC_W-1:0]  left_op, right_op, sum;
   logic                     running, req_take, out_free, over, rsp_load;

   assign running   = (state_ff == ST_RUN);
   assign req_stall = running;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = running && (uop.seq == SEQ_DONE) && out_free;
   assign csr_ready = 1'b1;
   assign uop       = taf_rom(pc_ff);

   // one-sided signed trip test on the incoming item
   assign over = (req_force_x > $signed({1'b0, force_limit_ff})) ||
                 (req_force_y > $signed({1'b0, force_limit_ff})) ||
                 (req_force_z > $signed({1'b0, force_limit_ff}));

   always_comb begin
      unique case (uop.a_sel)
         MA_VEL:  mul_a = {vel_ff[ax_ff][31], vel_ff[ax_ff]};
         MA_POS:  mul_a = {pos_ff[ax_ff][31], pos_ff[ax_ff]};
         MA_ACC:  mul_a = acc_ff[MA_W-1:0];
         default: mul_a = '0;
      endcase
      unique case (uop.b_sel)
         MB_DAMP:  mul_b = damping_ff;
         MB_STIFF: mul_b = stiffness_ff;
         MB_IMASS: mul_b = inv_mass_ff;
         MB_TSTEP: mul_b = time_step_ff;
         default:  mul_b = '0;
      endcase
   end

   assign prod = mul_a * $signed({1'b0, mul_b});

   // round half up, then floor
   always_comb begin
      unique case (uop.shift)
         RS_16: begin
            rnd_sum     = p_ff + 58'sd32768;
            rnd_shifted = rnd_sum >>> 16;
         end
         RS_17: begin
            rnd_sum     = p_ff + 58'sd65536;
            rnd_shifted = rnd_sum >>> 17;
         end
         RS_24: begin
            rnd_sum     = p_ff + 58'sd8388608;
            rnd_shifted = rnd_sum >>> 24;
         end
         RS_25: begin
            rnd_sum     = p_ff + 58'sd16777216;
            rnd_shifted = rnd_sum >>> 25;
         end
         default: begin
            rnd_sum     = p_ff;
            rnd_shifted = p_ff;
         end
      endcase
   end

   always_comb begin
      unique case (uop.l_sel)
         L_ACC:   left_op = acc_ff;
         L_FORCE: left_op = {{(ACC_W-32){force_ff[ax_ff][31]}}, force_ff[ax_ff]};
         L_VEL:   left_op = {{(ACC_W-32){vel_ff[ax_ff][31]}}, vel_ff[ax_ff]};
         L_POS:   left_op = {{(ACC_W-32){pos_ff[ax_ff][31]}}, pos_ff[ax_ff]};
         default: left_op = '0;
      endcase
      unique case (uop.r_sel)
         R_RND:   right_op = rnd_shifted[ACC_W-1:0];
         R_PACC:  right_op = {{(ACC_W-32){pacc_ff[ax_ff][31]}}, pacc_ff[ax_ff]};
         R_PVEL:  right_op = {{(ACC_W-32){pvel_ff[ax_ff][31]}}, pvel_ff[ax_ff]};
         default: right_op = '0;
      endcase
      sum = uop.r_neg ? (left_op - right_op) : (left_op + right_op);
      acc_in = acc_ff;
      if (running && uop.acc_en) begin
         if (uop.sat && sum > SAT_MAX) begin
            acc_in = SAT_MAX;
         end else if (uop.sat && sum < SAT_MIN) begin
            acc_in = SAT_MIN;
         end else begin
            acc_in = sum;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff    <= RST_INV_MASS;
         stiffness_ff   <= RST_STIFFNESS;
         damping_ff     <= RST_DAMPING;
         time_step_ff   <= RST_TIME_STEP;
         force_limit_ff <= RST_FORCE_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INV_MASS:    inv_mass_ff    <= csr_wdata[23:0];
            CSR_STIFFNESS:   stiffness_ff   <= csr_wdata[23:0];
            CSR_DAMPING:     damping_ff     <= csr_wdata[23:0];
            CSR_TIME_STEP:   time_step_ff   <= csr_wdata[23:0];
            CSR_FORCE_LIMIT: force_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         ax_ff        <= '0;
         trip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_RUN;
                  pc_ff    <= '0;
                  ax_ff    <= '0;
                  trip_ff  <= trip_ff | over;
               end
            end
            ST_RUN: begin
               unique case (uop.seq)
                  SEQ_NEXT: pc_ff <= pc_ff + 1'b1;
                  SEQ_JMP_TRIP: pc_ff <= trip_ff ? uop.target : pc_ff + 1'b1;
                  SEQ_LOOP: begin
                     if (ax_ff == AX_W'(AXES - 1)) begin
                        pc_ff <= pc_ff + 1'b1;
                     end else begin
                        ax_ff <= ax_ff + 1'b1;
                        pc_ff <= uop.target;
                     end
                  end
                  SEQ_DONE: begin
                     if (out_free) begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  default: pc_ff <= pc_ff;
               endcase
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            vel_ff[i]  <= '0;
            pos_ff[i]  <= '0;
            pacc_ff[i] <= '0;
            pvel_ff[i] <= '0;
         end
      end else if (running) begin
         case (uop.wr)
            WR_PACC: pacc_ff[ax_ff] <= acc_ff[31:0];
            WR_VEL: begin
               vel_ff[ax_ff]  <= acc_ff[31:0];
               pvel_ff[ax_ff] <= acc_ff[31:0];
            end
            WR_POS:  pos_ff[ax_ff] <= acc_ff[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (running && uop.mul_en) begin
         p_ff <= prod;
      end
      if (req_take) begin
         force_ff[0] <= req_force_x;
         force_ff[1] <= req_force_y;
         force_ff[2] <= req_force_z;
      end
      if (rsp_load) begin
         for (int i = 0; i < AXES; i++) begin
            rsp_vel_ff[i] <= vel_ff[i];
            rsp_pos_ff[i] <= pos_ff[i];
         end
         rsp_tripped_ff <= trip_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vel_x   = rsp_vel_ff[0];
   assign rsp_vel_y   = rsp_vel_ff[1];
   assign rsp_vel_z   = rsp_vel_ff[2];
   assign rsp_pos_x   = rsp_pos_ff[0];
   assign rsp_pos_y   = rsp_pos_ff[1];
   assign rsp_pos_z   = rsp_pos_ff[2];
   assign rsp_tripped = rsp_tripped_ff;

   // trip latch is sticky until reset
   a_trip_sticky: assert property (@(posedge clock) disable iff (reset)
      trip_ff |=> trip_ff)
      else $error("trip latch cleared without reset");

   // a tripped item skips straight to the result step
   a_trip_skip: assert property (@(posedge clock) disable iff (reset)
      (running && pc_ff == '0 && trip_ff) |=> (pc_ff == PC_DONE))
      else $error("tripped item did not skip the update");

   // filter state is never written while tripped
   a_no_write_tripped: assert property (@(posedge clock) disable iff (reset)
      (running && uop.wr != WR_NONE) |-> !trip_ff)
      else $error("state written while tripped");

   // program counter stays inside the microprogram
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (pc_ff <= PC_DONE))
      else $error("program counter out of range");

endmodule

`default_nettype wire

@@ tb/tb_translational_admittance_filter_top.sv @@
// self-checking bench for translational_admittance_filter_top: directed rows,
// random force bursts over several register settings, trip check at the end
// depends on taf_pkg and translational_admittance_filter_top
`timescale 1ns / 1ps

module tb_translational_admittance_filter_top
   import taf_pkg::*;
();

   localparam int PHASES       = 11;
   localparam int PHASE_ITEMS  = 150;
   localparam int MAX_CYCLES   = 600000;
   localparam int DRAIN_CYCLES = 50;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 40;

   // indices past force_limit are not mapped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_MID = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI  = 3'd7;

   localparam logic signed [31:0] F_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] F_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] vel_x, vel_y, vel_z;
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic               tripped;
   } motion_type;

   localparam motion_type NO_MOTION = '0;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DAT_W-1:0]   data;
      logic signed [31:0]     fx, fy, fz;
      bit                     zero_expected;
   } bench_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [31:0]      req_force_x, req_force_y, req_force_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [31:0]      rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic signed [31:0]      rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic                    rsp_tripped;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DAT_W-1:0]    csr_wdata;

   // filter configuration and state as the block should hold them
   longint inv_mass_q = RST_INV_MASS;
   longint stiff_q    = RST_STIFFNESS;
   longint damp_q     = RST_DAMPING;
   longint tstep_q    = RST_TIME_STEP;
   longint limit_q    = RST_FORCE_LIMIT;
   int     vel_q[3]      = '{0, 0, 0};
   int     pos_q[3]      = '{0, 0, 0};
   int     acc_prev_q[3] = '{0, 0, 0};
   int     vel_prev_q[3] = '{0, 0, 0};
   bit     tripped_q     = 1'b0;

   motion_type    pending_motion[$];
   bench_row_type bench_rows[$];
   int            trip_first;
   int            fail_count = 0;
   int            cycle_count = 0;
   bit            quiet = 1'b0;
   bit            hold_req = 1'b0;

   translational_admittance_filter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_force_x (req_force_x),
      .req_force_y (req_force_y),
      .req_force_z (req_force_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_vel_x   (rsp_vel_x),
      .rsp_vel_y   (rsp_vel_y),
      .rsp_vel_z   (rsp_vel_z),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z),
      .rsp_tripped (rsp_tripped),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < MAX_CYCLES) @(posedge clock) cycle_count++;
      $display("tb_translational_admittance_filter_top: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint round_shift_q(longint x, int s);
      longint half;
      half = longint'(1) << (s - 1);
      return (x + half) >>> s;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > longint'(F_MAX)) return longint'(F_MAX);
      if (x < longint'(F_MIN)) return longint'(F_MIN);
      return x;
   endfunction

   function automatic motion_type advance_filter(logic signed [31:0] fx, fy, fz);
      longint     fin[3];
      longint     dterm, kterm, net, acc, vnew, pnew;
      motion_type m;
      fin[0] = longint'(fx);
      fin[1] = longint'(fy);
      fin[2] = longint'(fz);
      // trip test is one-sided and comes before the update
      for (int i = 0; i < AXES; i++)
         if (fin[i] > limit_q) tripped_q = 1'b1;
      if (!tripped_q) begin
         for (int i = 0; i < AXES; i++) begin
            dterm = round_shift_q(damp_q * longint'(vel_q[i]), 16);
            kterm = round_shift_q(stiff_q * longint'(pos_q[i]), 16);
            net   = clamp32(fin[i] - dterm - kterm);
            acc   = clamp32(round_shift_q(net * inv_mass_q, 24));
            vnew  = clamp32(longint'(vel_q[i]) + round_shift_q(
                       (acc + longint'(acc_prev_q[i])) * tstep_q, 17));
            pnew  = clamp32(longint'(pos_q[i]) + round_shift_q(
                       (vnew + longint'(vel_prev_q[i])) * tstep_q, 25));
            vel_q[i]      = int'(vnew);
            pos_q[i]      = int'(pnew);
            acc_prev_q[i] = int'(acc);
            vel_prev_q[i] = int'(vnew);
         end
      end
      m.vel_x   = vel_q[0];
      m.vel_y   = vel_q[1];
      m.vel_z   = vel_q[2];
      m.pos_x   = pos_q[0];
      m.pos_y   = pos_q[1];
      m.pos_z   = pos_q[2];
      m.tripped = tripped_q;
      return m;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic bench_row_type item_row(logic signed [31:0] fx, fy, fz,
                                              bit zero_expected = 1'b0);
      bench_row_type r;
      r = '{ROW_ITEM, '0, '0, fx, fy, fz, zero_expected};
      return r;
   endfunction

   function automatic bench_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                             logic [CSR_DAT_W-1:0] data);
      bench_row_type r;
      r = '{ROW_CSR, idx, data, '0, '0, '0, 1'b0};
      return r;
   endfunction

   // positive forces above the limit would trip the latch for good
   function automatic logic signed [31:0] keep_below(logic signed [31:0] v);
      if (longint'(v) > limit_q) return -v;
      return v;
   endfunction

   function automatic logic signed [31:0] rand_force();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 32'($urandom_range(0, 1 << 21)) - 32'sd1048576;
         4, 5:       v = 32'($urandom_range(0, 1 << 27)) - 32'sd67108864;
         6, 7:       v = $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0:       v = F_MAX;
               1:       v = F_MIN;
               2:       v = '0;
               default: v = '1;
            endcase
         end
      endcase
      return keep_below(v);
   endfunction

   function automatic logic [23:0] extreme24();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INV_MASS:    inv_mass_q = longint'(data[23:0]);
         CSR_STIFFNESS:   stiff_q    = longint'(data[23:0]);
         CSR_DAMPING:     damp_q     = longint'(data[23:0]);
         CSR_TIME_STEP:   tstep_q    = longint'(data[23:0]);
         CSR_FORCE_LIMIT: limit_q    = longint'(data[30:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_force(logic signed [31:0] fx, fy, fz, bit zero_expected);
      motion_type m;
      while (!quiet && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_force_x <= fx;
      req_force_y <= fy;
      req_force_z <= fz;
      do @(posedge clock); while (req_stall);
      m = advance_filter(fx, fy, fz);
      pending_motion.push_back(zero_expected ? NO_MOTION : m);
   endtask

   task automatic run_rows(int lo, int hi);
      for (int i = lo; i <= hi; i++) begin
         if (bench_rows[i].kind == ROW_CSR)
            write_csr(bench_rows[i].idx, bench_rows[i].data);
         else
            send_force(bench_rows[i].fx, bench_rows[i].fy, bench_rows[i].fz,
                       bench_rows[i].zero_expected);
      end
   endtask

   task automatic set_phase_config(int p);
      logic [23:0] im, k, d, ts;
      logic [30:0] lim;
      if (p == 0) begin
         im = RST_INV_MASS;
         k  = RST_STIFFNESS;
         d  = RST_DAMPING;
         ts = RST_TIME_STEP;
      end else if (p % 3 == 2) begin
         im = extreme24();
         k  = extreme24();
         d  = extreme24();
         ts = extreme24();
      end else begin
         im = 24'($urandom_range(1 << 16, 1 << 21));
         k  = 24'($urandom_range(0, 1 << 17));
         d  = 24'($urandom_range(0, 1 << 15));
         ts = 24'($urandom_range(1 << 12, 1 << 17));
      end
      if (p == 3)      lim = '0;
      else if (p == 7) lim = 31'($urandom_range(0, 1 << 24));
      else             lim = 31'h7fffffff;
      // junk in the unused upper bits must be dropped
      write_csr(CSR_INV_MASS,    {7'($urandom), im});
      write_csr(CSR_STIFFNESS,   {7'($urandom), k});
      write_csr(CSR_DAMPING,     {7'($urandom), d});
      write_csr(CSR_TIME_STEP,   {7'($urandom), ts});
      write_csr(CSR_FORCE_LIMIT, lim);
   endtask

   // ---------------------------------------------------------------- response side

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 37);
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $time, name,
                     $signed(want), $signed(got));
      end
   endtask

   initial begin : result_check
      motion_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_motion.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: result item with none expected, expected none got vel_x %0d",
                           $time, rsp_vel_x);
            end else begin
               want = pending_motion.pop_front();
               check_field("vel_x", want.vel_x, rsp_vel_x);
               check_field("vel_y", want.vel_y, rsp_vel_y);
               check_field("vel_z", want.vel_z, rsp_vel_z);
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("pos_z", want.pos_z, rsp_pos_z);
               check_field("tripped", {31'b0, want.tripped}, {31'b0, rsp_tripped});
            end
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      logic signed [31:0] base[3];
      logic signed [31:0] f[3];
      int                 burst_left;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_force_x <= '0;
      req_force_y <= '0;
      req_force_z <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;

      // zero state and zero force give zero motion
      bench_rows.push_back(item_row(0, 0, 0, 1'b1));
      bench_rows.push_back(csr_row(CSR_UNMAPPED_LO, '1));
      bench_rows.push_back(csr_row(CSR_UNMAPPED_MID, '0));
      bench_rows.push_back(csr_row(CSR_UNMAPPED_HI, '1));
      bench_rows.push_back(item_row(0, 0, 0, 1'b1));
      // force equal to the limit does not trip
      bench_rows.push_back(item_row(32'sd65536, -32'sd65536, 32'sd4587520));
      bench_rows.push_back(item_row(32'sd4587520, 32'sd4587520, F_MIN));
      bench_rows.push_back(item_row(F_MIN, F_MIN, F_MIN));
      bench_rows.push_back(item_row(-32'sd1, 32'sd1, 32'sd0));
      bench_rows.push_back(csr_row(CSR_FORCE_LIMIT, 31'h7fffffff));
      bench_rows.push_back(item_row(F_MAX, F_MAX, F_MAX));
      bench_rows.push_back(item_row(F_MAX, F_MIN, F_MAX));
      bench_rows.push_back(item_row(32'sh55555555, 32'shaaaaaaaa, 32'sd0));
      bench_rows.push_back(item_row(32'shaaaaaaaa, 32'sh55555555, -32'sd1));
      // every gain at its top: saturation on all paths
      bench_rows.push_back(csr_row(CSR_INV_MASS, 31'hffffff));
      bench_rows.push_back(csr_row(CSR_STIFFNESS, 31'hffffff));
      bench_rows.push_back(csr_row(CSR_DAMPING, 31'hffffff));
      bench_rows.push_back(csr_row(CSR_TIME_STEP, 31'hffffff));
      bench_rows.push_back(item_row(F_MAX, F_MIN, 32'sd0));
      bench_rows.push_back(item_row(F_MIN, F_MAX, 32'sd0));
      bench_rows.push_back(item_row(32'sd0, 32'sd0, 32'sd0));
      // zero inverse mass: no acceleration
      bench_rows.push_back(csr_row(CSR_INV_MASS, 31'd0));
      bench_rows.push_back(item_row(F_MAX, F_MAX, F_MAX));
      bench_rows.push_back(item_row(F_MIN, F_MIN, F_MIN));
      // zero time step: velocity and position frozen
      bench_rows.push_back(csr_row(CSR_INV_MASS, 31'(RST_INV_MASS)));
      bench_rows.push_back(csr_row(CSR_TIME_STEP, 31'd0));
      bench_rows.push_back(item_row(32'sd1048576, -32'sd1048576, 32'sd65536));
      bench_rows.push_back(item_row(F_MAX, 32'sd0, F_MIN));
      bench_rows.push_back(csr_row(CSR_STIFFNESS, 31'd0));
      bench_rows.push_back(csr_row(CSR_DAMPING, 31'd0));
      bench_rows.push_back(csr_row(CSR_TIME_STEP, 31'(RST_TIME_STEP)));
      bench_rows.push_back(item_row(32'sd65536, 32'sd131072, -32'sd65536));
      bench_rows.push_back(item_row(32'sd65536, 32'sd131072, -32'sd65536));
      bench_rows.push_back(csr_row(CSR_STIFFNESS, 31'(RST_STIFFNESS)));
      bench_rows.push_back(csr_row(CSR_DAMPING, 31'(RST_DAMPING)));

      // trip tail: the latch is sticky, so this runs last
      trip_first = bench_rows.size();
      bench_rows.push_back(csr_row(CSR_FORCE_LIMIT, 31'd1000));
      bench_rows.push_back(item_row(32'sd500, F_MIN, 32'sd1000));
      bench_rows.push_back(item_row(32'sd1000, 32'sd1000, 32'sd1000));
      bench_rows.push_back(item_row(32'sd0, 32'sd1001, 32'sd0));
      bench_rows.push_back(item_row(32'sd0, 32'sd0, 32'sd0));
      bench_rows.push_back(item_row(F_MAX, F_MAX, F_MAX));
      bench_rows.push_back(item_row(F_MIN, 32'sd5, 32'sd0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_rows(0, trip_first - 1);

      for (int p = 0; p < PHASES; p++) begin
         set_phase_config(p);
         quiet      = (p == 4);
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == 40) hold_req = 1'b1;
            // step inputs held for a while with a little noise on top
            if (burst_left == 0) begin
               for (int a = 0; a < 3; a++) base[a] = rand_force();
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            for (int a = 0; a < 3; a++) begin
               if ($urandom_range(0, 4) == 0)
                  f[a] = rand_force();
               else
                  f[a] = keep_below(base[a] ^ 32'($urandom_range(0, 255)));
            end
            send_force(f[0], f[1], f[2], 1'b0);
         end
      end
      quiet = 1'b0;

      run_rows(trip_first, bench_rows.size() - 1);
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb_translational_admittance_filter_top: PASS");
      else
         $display("tb_translational_admittance_filter_top: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/taf_pkg.sv
hw/rtl/translational_admittance_filter_top.sv
tb/tb_translational_admittance_filter_top.sv
